FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Invariant that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/bdh_pkg.sv
// Shared types and constants of the bark difference hash block.
package bdh_pkg;

    // configuration port
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ENERGY_THR = 2'd0;
    localparam cfg_idx_t CFG_DIFF_THR   = 2'd1;
    localparam cfg_idx_t CFG_TOGGLE_CNT = 2'd2;

    localparam int CFG_DATA_W   = 32;
    localparam int TOGGLE_CNT_W = 6;
    localparam int MAX_TOGGLES  = 32;

    // stream payloads
    localparam int BAND_W     = 32;
    localparam int HASH_W     = 32;
    localparam int RANK_W     = 5;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    // sequencer states
    localparam int ST_W = 3;
    typedef logic [ST_W-1:0] state_t;
    localparam state_t ST_BAND  = 3'd0;
    localparam state_t ST_CALC  = 3'd1;
    localparam state_t ST_WRITE = 3'd2;
    localparam state_t ST_SCAN  = 3'd3;
    localparam state_t ST_DRAIN = 3'd4;
    localparam state_t ST_EMIT  = 3'd5;
    localparam state_t ST_EMIT0 = 3'd6;

endpackage

FILE: rtl/bdh_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module bdh_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bark_difference_hash_bits_core.sv
// Top level of the bark band energy difference hash block.
`include "assert_macros.svh"

// Bark band energy difference hash. Band energies (unsigned Q24.8) arrive one
// per transfer on the s_ stream, bands in ascending order, NUM_BANDS transfers
// to a frame. For each adjacent pair m the block forms D = E[m] - E[m+1] and
// H = D - D_prev[m] (H = D when s_tuser flags a first frame on band 0, and
// always for the first frame after reset). Hash bit m, pair 0 most
// significant, is set when either energy of the pair is above energy_threshold
// and H is above diff_threshold (signed compare). After the last band the
// block sends P = min(toggle_count, NUM_BANDS-1, 32) result transfers, rank 0
// first, each carrying the hash and the pair index with the k-th smallest H,
// in the order a swapping selection sort with strict less-than gives; with
// P = 0 it sends one transfer with m_tuser low. m_tlast marks the last one.
// Band 0 is only accepted; every other band is accepted, differenced against
// the stored previous frame and written back, in that order. After the last
// band, each rank is found with one RAM read per remaining candidate through
// the single read port of the difference RAM, plus drain and emit/swap; a
// result waits in the output register while the next rank is scanned.
// s_tready is high only between frames and between bands. No clearing pass is
// needed after reset.
// Configuration: cfg_index 0 energy_threshold, 1 diff_threshold,
// 2 toggle_count (low 6 bits); other indexes are ignored. cfg_ready is
// always high; write only while the block is idle.
module bark_difference_hash_bits_core #(
    parameter int NUM_BANDS    = 33,
    parameter int ENERGY_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  bdh_pkg::cfg_idx_t             cfg_index,
    input  logic [bdh_pkg::CFG_DATA_W-1:0] cfg_data,
    // band input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bdh_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] band_energy
    input  logic [0:0]                    s_tuser,   // [0] first_frame
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] hash_word, [36:32] toggle_rank, [41:37] toggle_bit_index,
    // [47:42] zero
    output logic [bdh_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                    m_tuser,   // [0] toggle_valid
    output logic                          m_tlast    // last_of_frame
);

    import bdh_pkg::*;

    localparam int PAIRS = NUM_BANDS - 1;
    localparam int IW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;  // pair index width
    localparam int CNTW  = $clog2(NUM_BANDS);
    localparam int EW    = ENERGY_WIDTH;
    localparam int DW    = EW + 1;                  // D, signed
    localparam int HW    = EW + 3;                  // H, signed
    localparam int CW    = (HW > 33) ? HW : 33;     // H vs threshold compare
    localparam int EXW   = (EW > 32) ? EW : 32;     // energy vs threshold compare
    localparam int MAXP  = (PAIRS < MAX_TOGGLES) ? PAIRS : MAX_TOGGLES;
    localparam int CURW  = HW + IW;                 // sort entry {index, H}

    // ---------------- registers ----------------
    state_t                    state_reg, state_next;
    logic [31:0]               energy_thr_reg, energy_thr_next;
    logic [31:0]               diff_thr_reg, diff_thr_next;
    logic [TOGGLE_CNT_W-1:0]   toggle_cnt_reg, toggle_cnt_next;

    logic [CNTW-1:0]           band_cnt_reg, band_cnt_next;
    logic                      first_reg, first_next;
    logic [EW-1:0]             prev_e_reg, prev_e_next;
    logic [HASH_W-1:0]         hash_reg, hash_next;
    logic signed [DW-1:0]      d_reg, d_next;
    logic                      strong_reg, strong_next;
    logic [IW-1:0]             m_reg, m_next;
    logic signed [HW-1:0]      h_reg, h_next;

    logic [TOGGLE_CNT_W-1:0]   count_reg, count_next;
    logic [IW-1:0]             i_reg, i_next;
    logic [IW-1:0]             j_reg, j_next;
    logic                      rv_reg, rv_next;
    logic [IW-1:0]             rpos_reg, rpos_next;
    logic signed [HW-1:0]      best_h_reg, best_h_next;
    logic [IW-1:0]             best_idx_reg, best_idx_next;
    logic [IW-1:0]             best_pos_reg, best_pos_next;
    logic [CURW-1:0]           vali_reg, vali_next;

    logic                      m_valid_reg, m_valid_next;
    logic [HASH_W-1:0]         m_hash_reg, m_hash_next;
    logic                      m_tv_reg, m_tv_next;
    logic [RANK_W-1:0]         m_rank_reg, m_rank_next;
    logic [RANK_W-1:0]         m_idx_reg, m_idx_next;
    logic                      m_last_reg, m_last_next;

    // ---------------- RAM ports ----------------
    logic              prev_we, prev_re;
    logic [IW-1:0]     prev_raddr;
    logic [DW-1:0]     prev_rd;
    logic              cur_we, cur_re;
    logic [IW-1:0]     cur_waddr, cur_raddr;
    logic [CURW-1:0]   cur_wdata, cur_rd;

    // previous frame's D per pair
    bdh_ram #(.WIDTH(DW), .DEPTH(PAIRS), .ADDR_W(IW)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (m_reg),
        .wdata (d_reg),
        .re    (prev_re),
        .raddr (prev_raddr),
        .rdata (prev_rd)
    );

    // this frame's H with pair index, reordered in place by the sort
    bdh_ram #(.WIDTH(CURW), .DEPTH(PAIRS), .ADDR_W(IW)) u_cur_ram (
        .aclk  (aclk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .re    (cur_re),
        .raddr (cur_raddr),
        .rdata (cur_rd)
    );

    // ---------------- datapath helpers ----------------
    logic                  s_xfer;
    logic                  out_free;
    logic [EW+31:0]        e_wide;
    logic [EW-1:0]         e_in;
    logic signed [HW-1:0]  h_calc;
    logic                  h_bit;
    logic signed [HW-1:0]  rd_h;
    logic [IW-1:0]         rd_idx;
    logic                  rd_less;
    logic [TOGGLE_CNT_W-1:0] count_calc;
    logic                  is_last_rank;
    logic [IW+RANK_W-1:0]  rank_wide, idx_wide;

    assign s_tready  = (state_reg == ST_BAND);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // band energy to EW bits (zero-extend or keep the low bits)
    assign e_wide = {{EW{1'b0}}, s_tdata[BAND_W-1:0]};
    assign e_in   = e_wide[EW-1:0];

    assign h_calc = first_reg ? HW'(d_reg) : (HW'(d_reg) - HW'($signed(prev_rd)));
    assign h_bit  = strong_reg && (CW'(h_reg) > CW'($signed({1'b0, diff_thr_reg})));

    assign rd_h    = $signed(cur_rd[HW-1:0]);
    assign rd_idx  = cur_rd[CURW-1:HW];
    assign rd_less = rd_h < best_h_reg;

    assign count_calc = (toggle_cnt_reg > TOGGLE_CNT_W'(MAXP)) ?
                        TOGGLE_CNT_W'(MAXP) : toggle_cnt_reg;
    assign is_last_rank = ((TOGGLE_CNT_W+1)'(i_reg) + 1'b1) == (TOGGLE_CNT_W+1)'(count_reg);

    assign rank_wide = {{RANK_W{1'b0}}, i_reg};
    assign idx_wide  = {{RANK_W{1'b0}}, best_idx_reg};

    assign prev_re    = s_xfer && (band_cnt_reg != '0);
    assign prev_raddr = IW'(band_cnt_reg - 1'b1);
    assign prev_we    = (state_reg == ST_CALC);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        energy_thr_next = energy_thr_reg;
        diff_thr_next   = diff_thr_reg;
        toggle_cnt_next = toggle_cnt_reg;
        band_cnt_next   = band_cnt_reg;
        first_next      = first_reg;
        prev_e_next     = prev_e_reg;
        hash_next       = hash_reg;
        d_next          = d_reg;
        strong_next     = strong_reg;
        m_next          = m_reg;
        h_next          = h_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        rv_next         = 1'b0;
        rpos_next       = rpos_reg;
        best_h_next     = best_h_reg;
        best_idx_next   = best_idx_reg;
        best_pos_next   = best_pos_reg;
        vali_next       = vali_reg;
        m_valid_next    = m_valid_reg;
        m_hash_next     = m_hash_reg;
        m_tv_next       = m_tv_reg;
        m_rank_next     = m_rank_reg;
        m_idx_next      = m_idx_reg;
        m_last_next     = m_last_reg;

        cur_we    = 1'b0;
        cur_waddr = m_reg;
        cur_wdata = {m_reg, h_reg};
        cur_re    = 1'b0;
        cur_raddr = j_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                CFG_ENERGY_THR: energy_thr_next = cfg_data;
                CFG_DIFF_THR:   diff_thr_next   = cfg_data;
                CFG_TOGGLE_CNT: toggle_cnt_next = cfg_data[TOGGLE_CNT_W-1:0];
                default: ;
            endcase
        end

        // scan data returning from the RAM
        if (rv_reg) begin
            if (rpos_reg == i_reg) begin
                best_h_next   = rd_h;
                best_idx_next = rd_idx;
                best_pos_next = i_reg;
                vali_next     = cur_rd;
            end else if (rd_less) begin
                best_h_next   = rd_h;
                best_idx_next = rd_idx;
                best_pos_next = rpos_reg;
            end
        end

        case (state_reg)
            ST_BAND: begin
                if (s_xfer) begin
                    prev_e_next = e_in;
                    if (band_cnt_reg == '0) begin
                        if (s_tuser[0]) begin
                            first_next = 1'b1;
                        end
                        hash_next     = '0;
                        band_cnt_next = CNTW'(1);
                    end else begin
                        d_next      = $signed({1'b0, prev_e_reg} - {1'b0, e_in});
                        strong_next = (EXW'(prev_e_reg) > EXW'(energy_thr_reg)) ||
                                      (EXW'(e_in) > EXW'(energy_thr_reg));
                        m_next      = prev_raddr;
                        state_next  = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                h_next     = h_calc;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cur_we    = 1'b1;
                hash_next = {hash_reg[HASH_W-2:0], h_bit};
                if (band_cnt_reg == CNTW'(NUM_BANDS - 1)) begin
                    band_cnt_next = '0;
                    first_next    = 1'b0;
                    count_next    = count_calc;
                    i_next        = '0;
                    j_next        = '0;
                    state_next    = (count_calc == '0) ? ST_EMIT0 : ST_SCAN;
                end else begin
                    band_cnt_next = band_cnt_reg + 1'b1;
                    state_next    = ST_BAND;
                end
            end
            ST_SCAN: begin
                cur_re    = 1'b1;
                rv_next   = 1'b1;
                rpos_next = j_reg;
                if (j_reg == IW'(PAIRS - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hash_next  = hash_reg;
                    m_tv_next    = 1'b1;
                    m_rank_next  = rank_wide[RANK_W-1:0];
                    m_idx_next   = idx_wide[RANK_W-1:0];
                    m_last_next  = is_last_rank;
                    // swap: the entry at the rank position moves to the winner's slot
                    if (best_pos_reg != i_reg) begin
                        cur_we    = 1'b1;
                        cur_waddr = best_pos_reg;
                        cur_wdata = vali_reg;
                    end
                    if (is_last_rank) begin
                        state_next = ST_BAND;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        j_next     = i_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_EMIT0: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hash_next  = hash_reg;
                    m_tv_next    = 1'b0;
                    m_rank_next  = '0;
                    m_idx_next   = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_BAND;
                end
            end
            default: begin
                state_next = ST_BAND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_BAND;
            energy_thr_reg <= 32'd25600;
            diff_thr_reg   <= 32'd2560;
            toggle_cnt_reg <= '0;
            band_cnt_reg   <= '0;
            first_reg      <= 1'b1;
            prev_e_reg     <= '0;
            hash_reg       <= '0;
            rv_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            energy_thr_reg <= energy_thr_next;
            diff_thr_reg   <= diff_thr_next;
            toggle_cnt_reg <= toggle_cnt_next;
            band_cnt_reg   <= band_cnt_next;
            first_reg      <= first_next;
            prev_e_reg     <= prev_e_next;
            hash_reg       <= hash_next;
            rv_reg         <= rv_next;
            m_valid_reg    <= m_valid_next;
        end
        d_reg        <= d_next;
        strong_reg   <= strong_next;
        m_reg        <= m_next;
        h_reg        <= h_next;
        count_reg    <= count_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        rpos_reg     <= rpos_next;
        best_h_reg   <= best_h_next;
        best_idx_reg <= best_idx_next;
        best_pos_reg <= best_pos_next;
        vali_reg     <= vali_next;
        m_hash_reg   <= m_hash_next;
        m_tv_reg     <= m_tv_next;
        m_rank_reg   <= m_rank_next;
        m_idx_reg    <= m_idx_next;
        m_last_reg   <= m_last_next;
    end

    // ---------------- outputs ----------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - HASH_W - 2*RANK_W){1'b0}},
                       m_idx_reg, m_rank_reg, m_hash_reg};
    assign m_tuser  = m_tv_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    `ASSERT_ALWAYS(a_band_cnt_range, aclk, aresetn, band_cnt_reg < CNTW'(NUM_BANDS - 1) ||
                   band_cnt_reg == CNTW'(NUM_BANDS - 1))
    `ASSERT_ALWAYS(a_cur_port_excl, aclk, aresetn, !(cur_we && cur_re))
    `ASSERT_IMPLY(a_sort_between_frames, aclk, aresetn,
                  state_reg == ST_SCAN || state_reg == ST_DRAIN || state_reg == ST_EMIT,
                  band_cnt_reg == '0 && (TOGGLE_CNT_W+1)'(i_reg) < (TOGGLE_CNT_W+1)'(count_reg))
    `ASSERT_NEXT(a_drain_to_emit, aclk, aresetn, state_reg == ST_DRAIN,
                 state_reg == ST_EMIT && !rv_reg)

endmodule

FILE: tb/tb_bark_difference_hash_bits_core.sv
// Self-checking testbench for the bark band energy difference hash block.
`timescale 1ns / 100ps

module tb_bark_difference_hash_bits_core;
    import bdh_pkg::*;

    localparam int BANDS         = 33;
    localparam int PAIRS         = BANDS - 1;
    localparam int DRAIN_CYCLES  = 40;      // idle margin once the last result is in
    localparam int CYCLE_LIMIT   = 200000;  // far above the length of a correct run
    localparam int PRESSURE_AT   = 70;      // lands inside the first frame of the P = 33 phase
    localparam int PRESSURE_HOLD = 500;
    localparam cfg_idx_t CFG_UNUSED = 2'd3; // index with no register behind it

    // how the band energies of a frame are drawn
    typedef enum int {
        FILL_DIRECTED,
        FILL_WIDE,
        FILL_TIES,
        FILL_CORNERS,
        FILL_NEAR_THR
    } fill_t;

    // band 0 first-frame flag
    typedef enum int {
        FLAG_CLEAR,
        FLAG_SET,
        FLAG_RANDOM
    } first_mode_t;

    typedef struct packed {
        logic [31:0] hash_word;
        logic        toggle_valid;
        logic [4:0]  rank;
        logic [4:0]  pair_index;
        logic        last;
    } frame_result_t;

    // Predicts the hash and the weakest-pair list of every frame, and holds the
    // results still owed by the block, oldest first.
    class hash_scoreboard;
        bit [31:0]         energy_thr;
        bit [31:0]         diff_thr;
        bit [5:0]          toggle_cnt;
        logic signed [33:0] last_diff [PAIRS];
        logic signed [34:0] frame_h [PAIRS];
        bit [31:0]         prev_energy;
        int                band_idx;
        bit [31:0]         hash_acc;
        bit                first_pending;
        frame_result_t     owed [$];
        int                errors;

        function new();
            energy_thr    = 32'd25600;
            diff_thr      = 32'd2560;
            toggle_cnt    = '0;
            prev_energy   = '0;
            band_idx      = 0;
            hash_acc      = '0;
            first_pending = 1'b1;
            errors        = 0;
        endfunction

        function void apply_reg(cfg_idx_t idx, bit [31:0] data);
            case (idx)
                CFG_ENERGY_THR: energy_thr = data;
                CFG_DIFF_THR:   diff_thr   = data;
                CFG_TOGGLE_CNT: toggle_cnt = data[5:0];
                default: ;
            endcase
        endfunction

        function void note_band(bit [31:0] energy, bit first);
            logic signed [33:0] d;
            logic signed [34:0] h;
            logic signed [34:0] vals [PAIRS];
            logic signed [34:0] tv;
            int                 order [PAIRS];
            int                 pair, count, best, ti, i, j;
            bit                 loud;
            frame_result_t      r;

            if (band_idx == 0) begin
                if (first)
                    first_pending = 1'b1;
                hash_acc    = '0;
                prev_energy = energy;
                band_idx    = 1;
                return;
            end

            pair = band_idx - 1;
            d = $signed({2'b00, prev_energy}) - $signed({2'b00, energy});
            h = first_pending ? d : d - last_diff[pair];
            last_diff[pair] = d;
            frame_h[pair]   = h;
            loud     = (prev_energy > energy_thr) || (energy > energy_thr);
            hash_acc = {hash_acc[30:0], loud && (h > $signed({3'b000, diff_thr}))};
            prev_energy = energy;

            if (band_idx < BANDS - 1) begin
                band_idx++;
                return;
            end

            band_idx      = 0;
            first_pending = 1'b0;
            count = (toggle_cnt > PAIRS) ? PAIRS : int'(toggle_cnt);

            if (count == 0) begin
                r = '{hash_word: hash_acc, toggle_valid: 1'b0, rank: 5'd0,
                      pair_index: 5'd0, last: 1'b1};
                owed.push_back(r);
                return;
            end

            // partial selection sort, strict less-than, with swaps
            for (i = 0; i < PAIRS; i++) begin
                vals[i]  = frame_h[i];
                order[i] = i;
            end
            for (i = 0; i < count; i++) begin
                best = i;
                for (j = i + 1; j < PAIRS; j++)
                    if (vals[j] < vals[best])
                        best = j;
                if (best != i) begin
                    tv = vals[i];      vals[i]  = vals[best];  vals[best]  = tv;
                    ti = order[i];     order[i] = order[best]; order[best] = ti;
                end
            end
            for (i = 0; i < count; i++) begin
                r.hash_word    = hash_acc;
                r.toggle_valid = 1'b1;
                r.rank         = i[4:0];
                r.pair_index   = order[i][4:0];
                r.last         = (i + 1 == count);
                owed.push_back(r);
            end
        endfunction

        function void check_result(bit [M_TDATA_W-1:0] tdata, bit tuser, bit tlast);
            frame_result_t exp_r;
            if (owed.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", tdata);
                errors++;
                return;
            end
            exp_r = owed.pop_front();
            if (tdata[31:0] !== exp_r.hash_word) begin
                $error("hash_word: expected %h, got %h", exp_r.hash_word, tdata[31:0]);
                errors++;
            end
            if (tuser !== exp_r.toggle_valid) begin
                $error("toggle_valid: expected %0d, got %0d", exp_r.toggle_valid, tuser);
                errors++;
            end
            if (tdata[36:32] !== exp_r.rank) begin
                $error("toggle_rank: expected %0d, got %0d", exp_r.rank, tdata[36:32]);
                errors++;
            end
            if (tdata[41:37] !== exp_r.pair_index) begin
                $error("toggle_bit_index: expected %0d, got %0d",
                       exp_r.pair_index, tdata[41:37]);
                errors++;
            end
            if (tlast !== exp_r.last) begin
                $error("last_of_frame: expected %0d, got %0d", exp_r.last, tlast);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [31:0] band_energy
    logic [0:0]            s_tuser;   // [0] first_frame
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [31:0] hash, [36:32] rank, [41:37] pair index
    logic [0:0]            m_tuser;   // [0] toggle_valid
    logic                  m_tlast;

    bit                    calm;      // both sides stop idling while set
    int unsigned           cycle_count;
    hash_scoreboard        sb;

    bark_difference_hash_bits_core #(
        .NUM_BANDS    (BANDS),
        .ENERGY_WIDTH (32)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: a hung handshake must not run forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_bark_difference_hash_bits_core failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic bit [31:0] draw_threshold();
        // half full range, half in the range where small energies live
        return $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 40000);
    endfunction

    // One register transfer; the caller drops cfg_valid after the last one.
    task automatic write_reg(input cfg_idx_t idx, input bit [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_reg(idx, data);
    endtask

    // All three registers plus a write to the unused index, which must be ignored.
    // Upper bits of the toggle count word are random to check the 6 bit mask.
    task automatic set_config(input bit [31:0] e_thr, input bit [31:0] d_thr,
                              input bit [5:0] toggles);
        bit [31:0] word;
        word      = $urandom();
        word[5:0] = toggles;
        write_reg(CFG_ENERGY_THR, e_thr);
        write_reg(CFG_DIFF_THR, d_thr);
        write_reg(CFG_TOGGLE_CNT, word);
        write_reg(CFG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // s_tvalid stays high straight into the next band when no gap is drawn.
    task automatic send_band(input bit [31:0] energy, input bit first);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= energy;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        sb.note_band(energy, first);
    endtask

    task automatic send_frame(input fill_t fill, input first_mode_t first_mode);
        bit [31:0] e;
        bit        f;
        int        b;
        for (b = 0; b < BANDS; b++) begin
            case (fill)
                // extremes, values either side of the default thresholds, and
                // an H that lands exactly on the difference threshold
                FILL_DIRECTED:
                    case (b % 6)
                        0: e = 32'hFFFF_FFFF;
                        1: e = 32'h0000_0000;
                        2: e = 32'd25601;
                        3: e = 32'd25600;
                        4: e = 32'd23040;
                        default: e = 32'hAAAA_AAAA;
                    endcase
                FILL_WIDE:     e = $urandom();
                FILL_TIES:     e = $urandom_range(0, 15);   // many equal H values
                FILL_CORNERS:
                    case ($urandom_range(0, 3))
                        0: e = 32'h0000_0000;
                        1: e = 32'hFFFF_FFFF;
                        2: e = 32'h8000_0000;
                        default: e = $urandom();
                    endcase
                default:       e = $urandom_range(0, 51200);
            endcase
            // the flag only counts on band 0; elsewhere it is random noise
            if (b == 0 && first_mode == FLAG_CLEAR)
                f = 1'b0;
            else if (b == 0 && first_mode == FLAG_SET)
                f = 1'b1;
            else
                f = $urandom_range(0, 1);
            send_band(e, f);
        end
    endtask

    // Block is idle once every owed result is in and a margin has passed.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result side: random back-pressure, plus one long hold while frames are
    // still being offered, so the output fills and s_tready drops.
    initial begin : result_sink
        int gap;
        int seen;
        seen = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = (seen == PRESSURE_AT) ? PRESSURE_HOLD : draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser[0], m_tlast);
            seen++;
        end
    end

    initial begin : stimulus
        sb          = new();
        calm        = 1'b0;
        cycle_count = 0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ENERGY_THR;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, P = 0: one result with no toggle. Band 0 flag clear,
        // yet the first frame after reset must still be treated as first.
        send_frame(FILL_DIRECTED, FLAG_CLEAR);
        wait_drained();

        // Zero thresholds, full toggle list, H taken against the last frame.
        set_config(32'h0000_0000, 32'h0000_0000, 6'd32);
        send_frame(FILL_WIDE, FLAG_CLEAR);
        wait_drained();

        // Top thresholds: hash stays zero; P of 63 saturates at 32. No idling.
        calm = 1'b1;
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_frame(FILL_CORNERS, FLAG_RANDOM);
        wait_drained();
        calm = 1'b0;

        // Single weakest pair among many ties.
        set_config(draw_threshold(), draw_threshold(), 6'd1);
        send_frame(FILL_TIES, FLAG_RANDOM);
        wait_drained();

        // P of 33 saturates; a forced restart then a continuing frame back to
        // back, with the long output hold falling in the first of them.
        set_config(draw_threshold(), draw_threshold(), 6'd33);
        send_frame(FILL_NEAR_THR, FLAG_SET);
        send_frame(FILL_TIES, FLAG_CLEAR);
        wait_drained();

        // Random P, without idling.
        set_config(draw_threshold(), draw_threshold(), 6'($urandom_range(2, 31)));
        calm = 1'b1;
        send_frame(FILL_NEAR_THR, FLAG_RANDOM);
        wait_drained();

        if (sb.pending() != 0)
            $error("%0d expected results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_bark_difference_hash_bits_core passed");
        end else begin
            $display("tb_bark_difference_hash_bits_core failed");
        end
        $finish;
    end

endmodule
